// ===== rtl/core/lzvd_pkg.sv =====
// shared types and constants of the lz varint stream decompressor
package lzvd_pkg;

  localparam int unsigned LZVD_WINDOW_DEPTH = 32768;
  localparam logic [31:0] LZVD_MIN_MATCH    = 32'd6;

  // command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_DIST    = 2'd1;
  localparam logic [1:0] ERR_REFUSED = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  typedef enum logic [7:0] {
    PH_HEADER   = 8'b0000_0001,
    PH_TOKEN    = 8'b0000_0010,
    PH_SECOND   = 8'b0000_0100,
    PH_LITERAL  = 8'b0000_1000,
    PH_COPY     = 8'b0001_0000,
    PH_DONE     = 8'b0010_0000,
    PH_ERR_DIST = 8'b0100_0000,
    PH_ERR_OVER = 8'b1000_0000
  } lzvd_phase_e;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } lzvd_in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       finished;
    logic [1:0] error_code;
  } lzvd_out_t;

endpackage

// ===== rtl/core/lzvd_stream_if.sv =====
// valid/ready stream interface carrying one payload struct
interface lzvd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lz_varint_stream_decompressor.sv =====
// lz varint stream decompressor: parser, history memory and output skid stage
//
//  channel | dir | payload                                        | transaction
//  in_i    | in  | command, in_byte                               | valid && ready
//  out_o   | out | byte_valid, out_byte, copy_pending, finished,  | valid && ready
//          |     | error_code                                     |
//
// one input transaction per cycle unless the output stalls, each giving exactly
// one result transaction; the result is registered in the history read stage
// and then in the output register
// the history memory is written in the cycle after the byte is accepted; a copy
// read of that same entry is forwarded from the write data
// reset clears all control state; the history needs no clearing pass
// a stalled output holds one result in the output register and one in the read stage
module lz_varint_stream_decompressor
  import lzvd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = LZVD_WINDOW_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lzvd_stream_if.sink   in_i,
  lzvd_stream_if.source out_o
);

  // address width and width of a distance that may equal the depth itself
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned DW = $clog2(WINDOW_DEPTH + 1);

  // parser state
  lzvd_phase_e   phase_q, phase_d;
  logic [31:0]   vacc_q, vacc_d;
  logic [2:0]    vbytes_q, vbytes_d;
  logic [2:0]    tlow_q, tlow_d;        // low three bits of token magnitude
  logic [31:0]   tlen_q, tlen_d;        // match length of the pending token
  logic [31:0]   run_q, run_d;
  logic [DW-1:0] dist_q, dist_d;
  logic [DW-1:0] prod_q, prod_d;        // bytes produced, saturated at the depth
  logic [31:0]   owed_q, owed_d;        // declared length minus bytes produced
  logic [AW-1:0] wp_q, wp_d;

  // handshake and pipeline control
  logic      acc;
  logic      move1;
  logic      s1_valid_q;
  logic      o_valid_q;
  lzvd_out_t s1_res_q;
  logic      s1_copy_q;
  lzvd_out_t o_res_q;
  lzvd_out_t s1_final;

  // step results
  lzvd_out_t res;
  logic      res_copy;
  logic      store;
  logic      rd_en;

  // varint decode
  logic [7:0]  b;
  logic [6:0]  grp;
  logic [31:0] vfin;
  logic        vdone;
  logic [31:0] run_lit;
  logic [31:0] mag;
  logic [34:0] dist_full;
  logic        dist_bad;

  // history memory and forwarding
  logic [7:0]    hist_mem [WINDOW_DEPTH];
  logic [7:0]    mem_q;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;
  logic          wr_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    wdata;
  logic [7:0]    copy_byte;
  logic [DW:0]   rd_idx;
  logic [AW-1:0] rd_addr;
  logic          fwd_hit;

  assign acc         = in_i.valid && in_i.ready;
  assign move1       = !o_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || move1;
  assign out_o.valid = o_valid_q;
  assign out_o.data  = o_res_q;

  assign b = in_i.data.in_byte;

  // varint byte: continuation bytes carry inverted groups, fifth byte gives top nibble
  always_comb begin
    grp   = b[7] ? ~b[6:0] : b[6:0];
    vdone = (vbytes_q >= 3'd4) || !b[7];
    unique case (vbytes_q)
      3'd0:    vfin = vacc_q | {25'b0, grp};
      3'd1:    vfin = vacc_q | {18'b0, grp, 7'b0};
      3'd2:    vfin = vacc_q | {11'b0, grp, 14'b0};
      3'd3:    vfin = vacc_q | {4'b0, grp, 21'b0};
      default: vfin = vacc_q | {b[3:0], 28'b0};
    endcase
  end

  assign run_lit   = {1'b0, vfin[31:1]};
  assign mag       = vfin[0] ? ({1'b0, vfin[31:1]} + 32'd1) : 32'd0;
  assign dist_full = {vfin, tlow_q};
  assign dist_bad  = (dist_full == 35'd0)
                  || (dist_full > 35'(prod_q))
                  || (dist_full > 35'(WINDOW_DEPTH));

  // copy source address, wrapping below the write pointer
  always_comb begin
    if ((DW + 1)'(wp_q) >= (DW + 1)'(dist_q)) begin
      rd_idx = (DW + 1)'(wp_q) - (DW + 1)'(dist_q);
    end else begin
      rd_idx = (DW + 1)'(wp_q) + (DW + 1)'(WINDOW_DEPTH) - (DW + 1)'(dist_q);
    end
  end
  assign rd_addr = rd_idx[AW-1:0];

  // next state of the parser for the accepted transaction
  always_comb begin
    phase_d  = phase_q;
    vacc_d   = vacc_q;
    vbytes_d = vbytes_q;
    tlow_d   = tlow_q;
    tlen_d   = tlen_q;
    run_d    = run_q;
    dist_d   = dist_q;
    prod_d   = prod_q;
    owed_d   = owed_q;
    wp_d     = wp_q;
    res      = '0;
    res_copy = 1'b0;
    store    = 1'b0;
    rd_en    = 1'b0;

    if (acc) begin
      unique case (phase_q)
        PH_ERR_DIST, PH_ERR_OVER: begin
        end
        PH_DONE: begin
          res.error_code = ERR_REFUSED;
        end
        PH_COPY: begin
          if (in_i.data.command != CMD_PULL) begin
            res.error_code = ERR_REFUSED;
          end else begin
            res.byte_valid = 1'b1;
            res_copy       = 1'b1;
            rd_en          = 1'b1;
            store          = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (in_i.data.command != CMD_BYTE) begin
            res.error_code = ERR_REFUSED;
          end else begin
            res.byte_valid = 1'b1;
            res.out_byte   = b;
            store          = 1'b1;
          end
        end
        PH_HEADER, PH_TOKEN, PH_SECOND: begin
          if (in_i.data.command != CMD_BYTE) begin
            res.error_code = ERR_REFUSED;
          end else if (!vdone) begin
            vacc_d   = vfin;
            vbytes_d = vbytes_q + 3'd1;
          end else begin
            vacc_d   = '0;
            vbytes_d = '0;
            if (phase_q == PH_HEADER) begin
              owed_d  = vfin;
              prod_d  = '0;
              phase_d = (vfin == 32'd0) ? PH_DONE : PH_TOKEN;
            end else if (phase_q == PH_TOKEN) begin
              if (!vfin[0] && (vfin != 32'd0)) begin
                // literal run
                if (run_lit > owed_q) begin
                  phase_d = PH_ERR_OVER;
                end else begin
                  run_d   = run_lit;
                  phase_d = PH_LITERAL;
                end
              end else begin
                // match token, distance follows
                tlow_d  = mag[2:0];
                tlen_d  = {3'b0, mag[31:3]} + LZVD_MIN_MATCH;
                phase_d = PH_SECOND;
              end
            end else begin
              // bad distance wins over overrun
              if (dist_bad) begin
                phase_d = PH_ERR_DIST;
              end else if (tlen_q > owed_q) begin
                phase_d = PH_ERR_OVER;
              end else begin
                dist_d  = dist_full[DW-1:0];
                run_d   = tlen_q;
                phase_d = PH_COPY;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (store) begin
        wp_d   = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        prod_d = (prod_q == DW'(WINDOW_DEPTH)) ? prod_q : prod_q + DW'(1);
        owed_d = owed_q - 32'd1;
        run_d  = run_q - 32'd1;
        // end of run: finished once nothing is owed
        if (run_q == 32'd1) begin
          phase_d = (owed_q == 32'd1) ? PH_DONE : PH_TOKEN;
        end
      end

      if (phase_d == PH_ERR_DIST) begin
        res.error_code = ERR_DIST;
      end else if (phase_d == PH_ERR_OVER) begin
        res.error_code = ERR_OVERRUN;
      end
      res.copy_pending = (phase_d == PH_COPY);
      res.finished     = (phase_d == PH_DONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      vacc_q   <= '0;
      vbytes_q <= '0;
      tlow_q   <= '0;
      tlen_q   <= '0;
      run_q    <= '0;
      dist_q   <= '0;
      prod_q   <= '0;
      owed_q   <= '0;
      wp_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      vacc_q   <= vacc_d;
      vbytes_q <= vbytes_d;
      tlow_q   <= tlow_d;
      tlen_q   <= tlen_d;
      run_q    <= run_d;
      dist_q   <= dist_d;
      prod_q   <= prod_d;
      owed_q   <= owed_d;
      wp_q     <= wp_d;
    end
  end

  // byte written in the cycle after acceptance: literal from the read stage,
  // copy from the memory read or the forwarded previous write
  assign copy_byte = fwd_q ? fwd_data_q : mem_q;
  assign wdata     = s1_copy_q ? copy_byte : s1_res_q.out_byte;
  assign fwd_hit   = wr_q && (wr_addr_q == rd_addr);

  always_ff @(posedge clk_i) begin
    if (wr_q) begin
      hist_mem[wr_addr_q] <= wdata;
    end
    if (rd_en) begin
      mem_q      <= hist_mem[rd_addr];
      fwd_q      <= fwd_hit;
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= 1'b0;
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      wr_q <= acc && store;
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (move1) begin
        s1_valid_q <= 1'b0;
      end
      if (move1) begin
        o_valid_q <= s1_valid_q;
      end
    end
  end

  // read stage result with the copied byte filled in
  always_comb begin
    s1_final = s1_res_q;
    if (s1_copy_q) begin
      s1_final.out_byte = copy_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q  <= res;
      s1_copy_q <= res_copy;
      wr_addr_q <= wp_q;
    end
    if (move1 && s1_valid_q) begin
      o_res_q <= s1_final;
    end
  end

endmodule

// ===== verif/lz_varint_stream_decompressor_tb.sv =====
// self-checking testbench for the lz varint stream decompressor
`timescale 1ns / 100ps

module lz_varint_stream_decompressor_tb;
  import lzvd_pkg::*;

  // history depth as seen by the predictor, matches the block default
  localparam int unsigned WIN          = LZVD_WINDOW_DEPTH;
  // share of cycles in which either side holds off while gaps are enabled
  localparam int unsigned IDLE_PCT     = 29;
  // input transactions after which the random stream of an error ending is closed off
  localparam int unsigned ITEM_TARGET  = 600;
  // length of the receiver hold-off in the back-pressure test
  localparam int unsigned HOLD_CYCLES  = 64;
  // cycles waited after the last expected result, before the verdict
  localparam int unsigned DRAIN_CYCLES = 8;
  // cycles with no transaction on either channel before giving up; the worst
  // correct case is the hold-off plus a long random gap on both sides
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // how the single stream of the run is brought to its terminal state
  typedef enum {
    FIN_CLEAN,
    FIN_DIST_ZERO,
    FIN_DIST_FAR,
    FIN_OVER_LIT,
    FIN_OVER_MATCH
  } stream_end_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  lzvd_stream_if #(.payload_t(lzvd_in_t))  in_if ();
  lzvd_stream_if #(.payload_t(lzvd_out_t)) out_if ();

  lz_varint_stream_decompressor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // ---------------------------------------------------------------------------
  // decoder state as the predictor sees it, starting from the reset values
  // ---------------------------------------------------------------------------
  lzvd_phase_e dec_phase = PH_HEADER;
  logic [31:0] vi_acc    = '0;  // varint bits gathered so far
  logic [2:0]  vi_cnt    = '0;  // varint bytes consumed so far
  logic [31:0] tok_mag   = '0;  // magnitude of a match token
  logic [31:0] run_left  = '0;  // bytes still owed by the current run or copy
  logic [31:0] cp_dist   = '0;  // distance of the current copy
  logic [31:0] out_count = '0;  // decompressed bytes produced
  logic [31:0] decl_len  = '0;  // length from the header
  int unsigned wr_ptr    = 0;
  logic [7:0]  hist_mem [WIN];  // only written entries are ever read

  // expected results in transaction order
  lzvd_out_t   expected_q [$];
  lzvd_out_t   want_res;
  lzvd_out_t   seen_res;

  // stimulus control
  stream_end_e stream_end;
  logic        gaps_on    = 1'b1;
  logic        hold_req   = 1'b0;
  int unsigned noise_pct  = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  int          fail_count = 0;

  // ---------------------------------------------------------------------------
  // predictor: one input transaction in, the one result it causes out
  // ---------------------------------------------------------------------------
  function automatic lzvd_out_t decode_step(input lzvd_in_t it);
    lzvd_out_t   res;
    logic [6:0]  grp;
    logic [31:0] word;
    logic        word_done;
    logic [34:0] span;
    logic [31:0] match_len;
    int unsigned rd_idx;
    res       = '0;
    word      = '0;
    word_done = 1'b0;
    case (dec_phase)
      // sticky error phases: the code is filled in below
      PH_ERR_DIST, PH_ERR_OVER: ;
      PH_DONE: res.error_code = ERR_REFUSED;
      PH_COPY, PH_LITERAL: begin
        // a copy wants pulls, a literal run wants bytes; anything else is refused
        if (it.command != ((dec_phase == PH_COPY) ? CMD_PULL : CMD_BYTE)) begin
          res.error_code = ERR_REFUSED;
        end else begin
          if (dec_phase == PH_COPY) begin
            rd_idx = (wr_ptr >= cp_dist) ? wr_ptr - cp_dist : wr_ptr + WIN - cp_dist;
            res.out_byte = hist_mem[rd_idx % WIN];
          end else begin
            res.out_byte = it.in_byte;
          end
          res.byte_valid   = 1'b1;
          hist_mem[wr_ptr] = res.out_byte;
          wr_ptr           = (wr_ptr + 1 >= WIN) ? 0 : wr_ptr + 1;
          out_count++;
          run_left--;
          if (run_left == 0) begin
            dec_phase = (out_count == decl_len) ? PH_DONE : PH_TOKEN;
          end
        end
      end
      default: begin
        if (it.command != CMD_BYTE) begin
          res.error_code = ERR_REFUSED;
        end else begin
          // varint byte: a fifth byte always ends it with bits 31..28
          if (vi_cnt >= 4) begin
            vi_acc[31:28] = vi_acc[31:28] | it.in_byte[3:0];
            word_done     = 1'b1;
          end else begin
            grp       = it.in_byte[7] ? ~it.in_byte[6:0] : it.in_byte[6:0];
            vi_acc    = vi_acc | ({25'd0, grp} << (7 * vi_cnt));
            word_done = !it.in_byte[7];
          end
          if (word_done) begin
            word   = vi_acc;
            vi_acc = '0;
            vi_cnt = '0;
          end else begin
            vi_cnt++;
          end
          if (word_done) begin
            case (dec_phase)
              PH_HEADER: begin
                decl_len  = word;
                out_count = '0;
                dec_phase = (word == 0) ? PH_DONE : PH_TOKEN;
              end
              PH_TOKEN: begin
                // even and non-zero: literal run, otherwise a match token
                if (!word[0] && word != 0) begin
                  if ((word >> 1) > decl_len - out_count) begin
                    dec_phase = PH_ERR_OVER;
                  end else begin
                    run_left  = word >> 1;
                    dec_phase = PH_LITERAL;
                  end
                end else begin
                  tok_mag   = word[0] ? (word >> 1) + 1 : '0;
                  dec_phase = PH_SECOND;
                end
              end
              default: begin
                // distance kept at full width, the distance check wins over overrun
                span      = {word, tok_mag[2:0]};
                match_len = (tok_mag >> 3) + LZVD_MIN_MATCH;
                if (span == 0 || span > out_count || span > WIN) begin
                  dec_phase = PH_ERR_DIST;
                end else if (match_len > decl_len - out_count) begin
                  dec_phase = PH_ERR_OVER;
                end else begin
                  cp_dist   = span[31:0];
                  run_left  = match_len;
                  dec_phase = PH_COPY;
                end
              end
            endcase
          end
        end
      end
    endcase
    if (dec_phase == PH_ERR_DIST) begin
      res.error_code = ERR_DIST;
    end else if (dec_phase == PH_ERR_OVER) begin
      res.error_code = ERR_OVERRUN;
    end
    res.copy_pending = (dec_phase == PH_COPY);
    res.finished     = (dec_phase == PH_DONE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one item, wait for its transaction, then record what it should give
  task automatic send_item(input logic cmd, input logic [7:0] byte_val);
    lzvd_in_t it;
    it.command = cmd;
    it.in_byte = byte_val;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(decode_step(it));
    items_sent++;
  endtask

  // occasional item of the wrong kind for the current phase
  task automatic maybe_noise(input logic cmd);
    if ($urandom_range(0, 99) < noise_pct) begin
      send_item(cmd, 8'($urandom));
    end
  endtask

  // varint encoder: continuation bytes carry inverted groups, and now and then
  // the encoding is padded out, up to the five byte form
  task automatic send_varint(input logic [31:0] v);
    int unsigned nb;
    int unsigned i;
    logic [7:0]  b;
    nb = 1;
    while (nb < 5 && (v >> (7 * nb)) != 0) nb++;
    if (nb < 5 && $urandom_range(0, 9) == 0) begin
      nb = $urandom_range(nb, 5);
    end
    for (i = 0; i < nb; i++) begin
      if (i == 4) begin
        b = {4'($urandom), v[31:28]};
      end else if (i == nb - 1) begin
        b = {1'b0, v[7 * i +: 7]};
      end else begin
        b = {1'b1, ~v[7 * i +: 7]};
      end
      maybe_noise(CMD_PULL);
      send_item(CMD_BYTE, b);
    end
  endtask

  task automatic send_literal(input int unsigned run);
    int unsigned i;
    send_varint(run << 1);
    for (i = 0; i < run; i++) begin
      maybe_noise(CMD_PULL);
      send_item(CMD_BYTE, 8'($urandom));
    end
  endtask

  // match token and second varint for a given length and distance, then pulls
  task automatic send_match(input int unsigned len, input int unsigned match_dist,
                            input int unsigned pulls);
    logic [31:0] mag;
    int unsigned i;
    mag = ((len - LZVD_MIN_MATCH) << 3) | (match_dist & 7);
    send_varint((mag == 0) ? 32'd0 : (((mag - 1) << 1) | 32'd1));
    send_varint(match_dist >> 3);
    for (i = 0; i < pulls; i++) begin
      maybe_noise(CMD_BYTE);
      send_item(CMD_PULL, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // pick how the stream ends and send the header; the distance error endings
  // sometimes declare a length that needs the full five byte varint
  task automatic test_header();
    stream_end = stream_end_e'($urandom_range(0, 4));
    send_item(CMD_PULL, 8'($urandom));  // pull before any header is refused
    if ((stream_end == FIN_DIST_ZERO || stream_end == FIN_DIST_FAR) &&
        $urandom_range(0, 1)) begin
      send_varint({4'($urandom_range(1, 15)), 28'($urandom)});
    end else begin
      send_varint($urandom_range(480, 600));
    end
  endtask

  // literal run with extreme byte values and a stray pull inside it
  task automatic test_literal_extremes();
    send_varint(32'd8);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_PULL, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h80);
    send_item(CMD_BYTE, 8'h7F);
  endtask

  // overlapping copy at distance one, a stray byte mid copy, and a zero token
  task automatic test_copies();
    send_match(6, 1, 3);
    send_item(CMD_BYTE, 8'hA5);
    repeat (3) send_item(CMD_PULL, 8'($urandom));
    send_match(6, 8, 6);
  endtask

  // receiver holds off while items keep coming, so the block must stall its input
  task automatic test_back_pressure();
    noise_pct = 4;
    hold_req  = 1'b1;
    send_literal(16);
    send_match(8, 3, 8);
  endtask

  // random tokens with random content until the stream is spent, or nearly so
  // for an error ending; the first part runs with no gaps on either side
  task automatic test_random_stream();
    logic [31:0] rem;
    int unsigned cap;
    int unsigned len;
    int unsigned match_dist;
    int unsigned start;
    logic        stop;
    start   = items_sent;
    gaps_on = 1'b0;
    stop    = 1'b0;
    while (!stop) begin
      if (items_sent >= start + 150) gaps_on = 1'b1;
      rem = decl_len - out_count;
      if (stream_end == FIN_CLEAN) begin
        stop = (rem == 0);
      end else begin
        stop = (items_sent >= ITEM_TARGET || rem < 24);
      end
      if (!stop) begin
        cap = (rem > 62) ? 62 : rem;
        if (cap >= 6 && $urandom_range(0, 1)) begin
          len  = $urandom_range(6, ($urandom_range(0, 3) == 0) ? cap :
                                   ((cap > 13) ? 13 : cap));
          match_dist = $urandom_range(0, 1) ?
                       $urandom_range(1, (out_count > 8) ? 8 : out_count) :
                       $urandom_range(1, (out_count > WIN) ? WIN : out_count);
          send_match(len, match_dist, len);
        end else begin
          send_literal($urandom_range(1, (cap > 12) ? 12 : cap));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // drive the stream into its terminal state, then check that it stays there
  task automatic test_stream_end();
    logic [31:0] rem;
    int unsigned len;
    rem = decl_len - out_count;
    case (stream_end)
      FIN_DIST_ZERO: send_match(6 + 8 * $urandom_range(0, 60), 0, 6);
      FIN_DIST_FAR: begin
        case ($urandom_range(0, 2))
          0: send_match(6 + $urandom_range(0, 40), out_count + $urandom_range(1, 40), 6);
          // distance that would look small if truncated to 32 bits
          1: begin
            send_varint(2 * $urandom_range(1, 40) - 1);
            send_varint(32'h2000_0000 | $urandom_range(0, 3));
          end
          default: begin
            send_varint(32'd1);
            send_varint(32'hFFFF_FFFF);
          end
        endcase
      end
      FIN_OVER_LIT: send_literal(rem + $urandom_range(1, 5));
      FIN_OVER_MATCH: begin
        if ($urandom_range(0, 1)) begin
          // all-ones zigzag token, magnitude two to the 31
          send_varint(32'hFFFF_FFFF);
          send_varint($urandom_range(1, out_count / 8));
        end else begin
          len = rem + $urandom_range(1, 8);
          if (len < 6) len = 6;
          send_match(len, $urandom_range(1, (out_count > WIN) ? WIN : out_count), 6);
        end
      end
      default: ;  // clean finish already reached by the random stream
    endcase
    repeat (12) send_item($urandom_range(0, 1) ? CMD_PULL : CMD_BYTE, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // clock, receiver, checker and watchdog
  // ---------------------------------------------------------------------------
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random back-pressure, plus a long hold-off counted here on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_if.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  // every result transaction is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_res = out_if.data;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, seen_res);
        fail_count++;
      end else begin
        want_res = expected_q.pop_front();
        check_field("byte_valid", want_res.byte_valid, seen_res.byte_valid);
        check_field("out_byte", want_res.out_byte, seen_res.out_byte);
        check_field("copy_pending", want_res.copy_pending, seen_res.copy_pending);
        check_field("finished", want_res.finished, seen_res.finished);
        check_field("error_code", want_res.error_code, seen_res.error_code);
      end
    end
  end

  // counts cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence: one stream from reset to its terminal state
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_header();
    test_literal_extremes();
    test_copies();
    test_back_pressure();
    test_random_stream();
    test_stream_end();
    in_if.valid <= 1'b0;

    // let the last results drain, then a few cycles for anything stray
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== lz_varint_stream_decompressor.f =====
rtl/core/lzvd_pkg.sv
rtl/core/lzvd_stream_if.sv
rtl/core/lz_varint_stream_decompressor.sv
verif/lz_varint_stream_decompressor_tb.sv
